/* design/afx_pkg.sv */
// Package with the constants, angle table and shared types of the full-turn angle unit.
package afx_pkg;

  // Width of the angle accumulator, radians scaled by 2^21.
  localparam int ZW = 24;
  // Width of the Q3.13 angle result.
  localparam int AngleWidth = 16;
  localparam int AtanTableLen = 24;

  // atan(2^-i) * 2^21, rounded to nearest.
  localparam logic signed [ZW-1:0] AtanSteps [AtanTableLen] = '{
    24'sd1647099, 24'sd972340, 24'sd513757, 24'sd260791,
    24'sd130902,  24'sd65515,  24'sd32765,  24'sd16384,
    24'sd8192,    24'sd4096,   24'sd2048,   24'sd1024,
    24'sd512,     24'sd256,    24'sd128,    24'sd64,
    24'sd32,      24'sd16,     24'sd8,      24'sd4,
    24'sd2,       24'sd1,      24'sd0,      24'sd0
  };

  // Upper clamp of the first-quadrant angle, pi/2 scaled by 2^21.
  localparam logic signed [ZW-1:0] AngHalfPiInt = 24'sd3294199;
  localparam logic [ZW-1:0] RoundHalf = 24'd128;

  // Angle constants in Q3.13 radians.
  localparam logic [AngleWidth-1:0] Q13HalfPi      = 16'd12868;
  localparam logic [AngleWidth-1:0] Q13Pi          = 16'd25736;
  localparam logic [AngleWidth-1:0] Q13ThreeHalfPi = 16'd38604;
  localparam logic [AngleWidth-1:0] Q13TwoPi       = 16'd51472;
  localparam logic [AngleWidth-1:0] Q13Zero        = 16'd0;

  // Quadrant and axis information that travels alongside the datapath.
  typedef struct packed {
    logic x_neg;
    logic y_neg;
    logic x_zero;
    logic y_zero;
  } afx_side_t;

endpackage

/* design/afx_if.sv */
// Valid/ready channel interfaces for coordinate pairs and angle results.
interface afx_coord_if #(
  parameter int COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] coord_x;
  logic signed [COORD_WIDTH-1:0] coord_y;

  modport source (output valid, output coord_x, output coord_y, input ready);
  modport sink (input valid, input coord_x, input coord_y, output ready);
endinterface

interface afx_angle_if;
  logic        valid;
  logic        ready;
  logic [15:0] angle;
  logic        origin_point;

  modport source (output valid, output angle, output origin_point, input ready);
  modport sink (input valid, input angle, input origin_point, output ready);
endinterface

/* design/angle_from_xy_full_turn_unit.sv */
// Pipelined CORDIC unit that returns the full-turn polar angle of an x,y pair.
// It has one input stage, one stage per CORDIC rotation and one output stage.
// Throughput is one transfer per cycle while the output is not stalled, set by the
// single add/subtract of one rotation that each stage holds. A stall on the
// output freezes every stage together. Reset clears only the stage valid bits.
module angle_from_xy_full_turn_unit #(
  parameter int ROTATION_STEPS = 16,
  parameter int COORD_WIDTH    = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  afx_coord_if.sink     coord_i,
  afx_angle_if.source   angle_o
);
  import afx_pkg::*;

  // The rotated x and y carry the coordinate magnitude scaled by 2^ROTATION_STEPS,
  // plus headroom for the CORDIC gain and the first rotation, which can double x.
  localparam int DW = COORD_WIDTH + ROTATION_STEPS + 3;
  localparam int LastStage = ROTATION_STEPS + 1;

  // Every stage advances together whenever the output register is empty or
  // its result is being taken in this cycle.
  logic adv;
  logic [LastStage:0] vld_q, vld_d;

  assign adv = !vld_q[LastStage] || angle_o.ready;
  assign coord_i.ready = adv;
  assign vld_d = {vld_q[LastStage-1:0], coord_i.valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  // Stage registers: index 0 is the input stage, index s+1 holds the result
  // of rotation s.
  logic signed [DW-1:0] cx_q [0:ROTATION_STEPS];
  logic signed [DW-1:0] cy_q [0:ROTATION_STEPS];
  logic signed [ZW-1:0] z_q  [0:ROTATION_STEPS];
  afx_side_t            side_q [0:ROTATION_STEPS];

  // Input stage: fold the pair into the first quadrant and note the signs and
  // the axis cases, which the output stage resolves without the CORDIC angle.
  logic signed [COORD_WIDTH-1:0] x_s, y_s;
  logic [COORD_WIDTH-1:0]        ax, ay;
  afx_side_t                     side_d;

  always_comb begin
    x_s = COORD_WIDTH'(coord_i.coord_x);
    y_s = COORD_WIDTH'(coord_i.coord_y);
    side_d.x_neg  = x_s[COORD_WIDTH-1];
    side_d.y_neg  = y_s[COORD_WIDTH-1];
    side_d.x_zero = (x_s == '0);
    side_d.y_zero = (y_s == '0);
    // The magnitude of the most negative value still fits as an unsigned number.
    ax = side_d.x_neg ? (~x_s + COORD_WIDTH'(1)) : x_s;
    ay = side_d.y_neg ? (~y_s + COORD_WIDTH'(1)) : y_s;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cx_q[0]   <= {3'b000, ax, {ROTATION_STEPS{1'b0}}};
      cy_q[0]   <= {3'b000, ay, {ROTATION_STEPS{1'b0}}};
      z_q[0]    <= '0;
      side_q[0] <= side_d;
    end
  end

  // One vectoring rotation per stage: drive y toward zero and accumulate the
  // angle that each rotation turns through.
  for (genvar s = 0; s < ROTATION_STEPS; s++) begin : g_rot
    logic signed [DW-1:0] dx, dy, cx_d, cy_d;
    logic signed [ZW-1:0] z_d;

    always_comb begin
      dx = cy_q[s] >>> s;
      dy = cx_q[s] >>> s;
      if (!cy_q[s][DW-1]) begin
        cx_d = cx_q[s] + dx;
        cy_d = cy_q[s] - dy;
        z_d  = z_q[s] + AtanSteps[s];
      end else begin
        cx_d = cx_q[s] - dx;
        cy_d = cy_q[s] + dy;
        z_d  = z_q[s] - AtanSteps[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        cx_q[s+1]   <= cx_d;
        cy_q[s+1]   <= cy_d;
        z_q[s+1]    <= z_d;
        side_q[s+1] <= side_q[s];
      end
    end
  end

  // Output stage: clamp the accumulated angle to [0, pi/2], round it to
  // Q3.13, then map it onto the full turn by quadrant. The axes and the
  // origin take exact constants.
  logic [ZW-1:0]         zc, zr;
  logic [AngleWidth-1:0] phi, angle_d, q4_angle;
  afx_side_t             side_l;
  logic                  origin_d;
  logic [AngleWidth-1:0] angle_q;
  logic                  origin_q;

  always_comb begin
    side_l = side_q[ROTATION_STEPS];
    if (z_q[ROTATION_STEPS][ZW-1]) begin
      zc = '0;
    end else if (z_q[ROTATION_STEPS] > AngHalfPiInt) begin
      zc = AngHalfPiInt;
    end else begin
      zc = z_q[ROTATION_STEPS];
    end
    zr  = zc + RoundHalf;
    phi = zr[ZW-1:8];

    // In the fourth quadrant a zero angle would give 2*pi, which wraps to 0.
    q4_angle = Q13TwoPi - phi;
    origin_d = side_l.x_zero && side_l.y_zero;

    if (origin_d) begin
      angle_d = Q13Zero;
    end else if (side_l.x_zero) begin
      angle_d = side_l.y_neg ? Q13ThreeHalfPi : Q13HalfPi;
    end else if (side_l.y_zero) begin
      angle_d = side_l.x_neg ? Q13Pi : Q13Zero;
    end else if (!side_l.x_neg && !side_l.y_neg) begin
      angle_d = phi;
    end else if (side_l.x_neg && !side_l.y_neg) begin
      angle_d = Q13Pi - phi;
    end else if (side_l.x_neg) begin
      angle_d = Q13Pi + phi;
    end else begin
      angle_d = (q4_angle >= Q13TwoPi) ? Q13Zero : q4_angle;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      angle_q  <= angle_d;
      origin_q <= origin_d;
    end
  end

  assign angle_o.valid        = vld_q[LastStage];
  assign angle_o.angle        = angle_q;
  assign angle_o.origin_point = origin_q;

endmodule
